/* hw/rtl/aar_pkg.sv */
package aar_pkg;

  localparam int NC_W   = 11;
  localparam int LIM_W  = 5;
  localparam int WT_W   = 18;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  localparam logic REG_NODE_COUNT   = 1'b0;
  localparam logic REG_RESULT_LIMIT = 1'b1;

  localparam logic CMD_EDGE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [NC_W-1:0]  nc;
    logic [LIM_W-1:0] limit;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE,
    S_F_RD,
    S_F_CHK,
    S_D_RD,
    S_D_ACC,
    S_W_CHK,
    S_C_RD,
    S_C_UPD,
    S_SEL,
    S_S_RD,
    S_S_CMP,
    S_EMIT,
    S_EMPTY,
    S_CLR
  } state_t;

  // 1/ln(d) in UQ2.16, evaluated at elaboration only
  function automatic logic [WT_W-1:0] inv_ln_q16(input int unsigned d);
    int unsigned n;
    logic [63:0] m;
    logic [63:0] lg;
    logic [63:0] ln;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] r;
    n = 0;
    for (int i = 1; i < 32; i++) begin
      if ((d >> i) != 0) n = i;
    end
    m = (64'(d) << 28) >> n;
    lg = 64'(n) << 28;
    for (int i = 27; i >= 0; i--) begin
      m = (m * m) >> 28;
      if (m >= (64'd1 << 29)) begin
        m = m >> 1;
        lg[i] = 1'b1;
      end
    end
    ln = (lg * LN2_Q32) >> 32;
    if (d < 2 || ln == 64'd0) return '0;
    num = (64'd1 << 44) + (ln >> 1);
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= ln) begin
        r = r - ln;
        q[b] = 1'b1;
      end
    end
    return q[WT_W-1:0];
  endfunction

endpackage

/* hw/rtl/aar_cmd_if.sv */
interface aar_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [5:0] first_node;
  logic [5:0] second_node;

  modport source(output valid, cmd, first_node, second_node, input ready);
  modport sink(input valid, cmd, first_node, second_node, output ready);
endinterface

/* hw/rtl/aar_rec_if.sv */
interface aar_rec_if;
  logic        valid;
  logic        ready;
  logic [5:0]  rec_node;
  logic [23:0] rec_score;
  logic        empty_res;
  logic        last;

  modport source(output valid, rec_node, rec_score, empty_res, last, input ready);
  modport sink(input valid, rec_node, rec_score, empty_res, last, output ready);
endinterface

/* hw/rtl/aar_cfg.sv */
module aar_cfg #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_RESULTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output aar_pkg::cfg_t      cfg
);

  localparam logic [aar_pkg::NC_W-1:0] NC_MAX = aar_pkg::NC_W'(MAX_NODES);
  localparam logic [6:0] LIM_MAX = 7'(MAX_RESULTS);
  localparam logic [6:0] LIM_RST = (LIM_MAX > 7'd4) ? 7'd4 : LIM_MAX;

  logic                        wr;
  logic [aar_pkg::NC_W-1:0]    nc_in;
  logic [6:0]                  lim_in;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && pready;
  assign nc_in = aar_pkg::NC_W'(pwdata[6:0]);
  assign lim_in = 7'(pwdata[4:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nc <= NC_MAX;
      cfg.limit <= LIM_RST[aar_pkg::LIM_W-1:0];
    end else if (wr) begin
      case (paddr[2])
        aar_pkg::REG_NODE_COUNT: begin
          cfg.nc <= (nc_in > NC_MAX) ? NC_MAX : nc_in;
        end
        aar_pkg::REG_RESULT_LIMIT: begin
          cfg.limit <= (lim_in > LIM_MAX) ? LIM_MAX[aar_pkg::LIM_W-1:0] :
                       lim_in[aar_pkg::LIM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      aar_pkg::REG_NODE_COUNT:   prdata = 32'(cfg.nc);
      aar_pkg::REG_RESULT_LIMIT: prdata = 32'(cfg.limit);
      default:                   prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/aar_adj_ram.sv */
// one bit per {row, column}; one write port, two registered read ports
module aar_adj_ram #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic          rdata_a,
  output logic          rdata_b
);

  logic mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hw/rtl/aar_score_ram.sv */
module aar_score_ram #(
  parameter int AW = 6,
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/adamic_adar_top_k_recommender_core.sv */
// Adamic-Adar friend recommender. Edge words (cmd 0) set both bits of the
// adjacency matrix, one as the word is taken and the other in S_EDGE; an
// ignored edge writes nothing and leaves the block idle. A query word (cmd 1)
// walks the adjacency matrix one bit per read through a single bit memory,
// using one shared add/saturate/compare unit, and output stalls hold it. The
// block takes no new word until the last result of a query is loaded into the
// output register. After reset the adjacency memory is cleared one bit per
// cycle, and no word is taken meanwhile. Scores live in a memory whose entries
// count as zero until marked in the candidate flags, so scores need no
// clearing pass.
module adamic_adar_top_k_recommender_core #(
  parameter int MAX_NODES   = 64,
  parameter int MAX_RESULTS = 16,
  parameter int SCORE_BITS  = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  aar_cmd_if.sink     cmd_ch,
  aar_rec_if.source   rec_ch
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int AAW = 2 * NW;
  localparam int XW  = aar_pkg::NC_W;
  localparam int DGW = $clog2(MAX_NODES + 1);
  localparam int MCW = $clog2(MAX_NODES + 1);
  localparam int SW  = ((SCORE_BITS > 24) ? SCORE_BITS : 24) + 1;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

  aar_pkg::cfg_t  cfg;
  aar_pkg::state_t state, state_next;

  logic [aar_pkg::WT_W-1:0] wtab [MAX_NODES+1];

  for (genvar d = 0; d <= MAX_NODES; d++) begin : g_wtab
    localparam logic [aar_pkg::WT_W-1:0] WV = aar_pkg::inv_ln_q16(d);
    assign wtab[d] = WV;
  end

  logic [NW-1:0]   u, ea, eb, f, j, c, best;
  logic [DGW-1:0]  cnt;
  logic [aar_pkg::WT_W-1:0] w;
  logic [aar_pkg::LIM_W-1:0] k;
  logic            found;
  logic [SCORE_BITS-1:0] bs;
  logic [MAX_NODES-1:0]  marks;
  logic [MCW-1:0]  mark_cnt;
  logic            out_valid;
  logic [5:0]      rec_node;
  logic [23:0]     rec_score;
  logic            empty_res;
  logic            last;

  logic            in_acc, out_free, out_load, edge_ok;
  logic [XW-1:0]   ax, bx;
  logic            f_last, j_last, c_last, hit, emit_last;
  logic            adj_we, adj_a, adj_b, adj_wdata;
  logic [2*NW-1:0] adj_waddr, adj_raddr_a, adj_raddr_b;
  logic [AAW-1:0]  clr_addr;
  logic            sc_we;
  logic [SCORE_BITS-1:0] sc_q, sc_old, sc_sat;
  logic [SW-1:0]   sc_sum, bs_x;
  logic [XW-1:0]   best_x;

  aar_cfg #(
    .MAX_NODES(MAX_NODES),
    .MAX_RESULTS(MAX_RESULTS)
  ) u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  aar_adj_ram #(.AW(2*NW)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .raddr_a(adj_raddr_a), .raddr_b(adj_raddr_b),
    .rdata_a(adj_a), .rdata_b(adj_b)
  );

  aar_score_ram #(.AW(NW), .DW(SCORE_BITS)) u_score (
    .clk(clk), .we(sc_we), .waddr(c), .wdata(sc_sat), .raddr(c), .rdata(sc_q)
  );

  assign in_acc   = cmd_ch.valid && cmd_ch.ready;
  assign out_free = !out_valid || rec_ch.ready;
  assign ax = XW'(cmd_ch.first_node);
  assign bx = XW'(cmd_ch.second_node);
  assign edge_ok = (ax != bx) && (ax < cfg.nc) && (bx < cfg.nc);

  assign f_last = (XW'(f) + XW'(1)) == cfg.nc;
  assign j_last = (XW'(j) + XW'(1)) == cfg.nc;
  assign c_last = (XW'(c) + XW'(1)) == cfg.nc;

  // candidate: neighbor of friend, not the user, not already a friend
  assign hit = (c != u) && adj_a && !adj_b;

  // shared add/saturate unit; unmarked entries read as zero
  assign sc_old = marks[c] ? sc_q : '0;
  assign sc_sum = SW'(sc_old) + SW'(w);
  assign sc_sat = (sc_sum > SW'(SCORE_MAX)) ? SCORE_MAX : sc_sum[SCORE_BITS-1:0];
  assign sc_we  = (state == aar_pkg::S_C_UPD) && hit;

  assign emit_last = ((k + aar_pkg::LIM_W'(1)) == cfg.limit) || (mark_cnt == MCW'(1));

  assign adj_we = (in_acc && cmd_ch.cmd == aar_pkg::CMD_EDGE && edge_ok) ||
                  (state == aar_pkg::S_EDGE) || (state == aar_pkg::S_CLR);
  assign adj_waddr = (state == aar_pkg::S_CLR) ? clr_addr :
                     (state == aar_pkg::S_EDGE) ? {eb, ea} :
                     {ax[NW-1:0], bx[NW-1:0]};
  assign adj_wdata = (state != aar_pkg::S_CLR);

  always_comb begin
    adj_raddr_a = {f, c};
    adj_raddr_b = {u, c};
    case (state)
      aar_pkg::S_F_RD: adj_raddr_a = {u, f};
      aar_pkg::S_D_RD: adj_raddr_a = {f, j};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aar_pkg::S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load = 1'b0;
    case (state)
      aar_pkg::S_CLR: begin
        if (clr_addr == '1) state_next = aar_pkg::S_IDLE;
      end
      aar_pkg::S_IDLE: begin
        if (in_acc) begin
          if (cmd_ch.cmd == aar_pkg::CMD_EDGE) begin
            state_next = edge_ok ? aar_pkg::S_EDGE : aar_pkg::S_IDLE;
          end else begin
            state_next = (ax < cfg.nc) ? aar_pkg::S_F_RD : aar_pkg::S_SEL;
          end
        end
      end
      aar_pkg::S_EDGE:  state_next = aar_pkg::S_IDLE;
      aar_pkg::S_F_RD:  state_next = aar_pkg::S_F_CHK;
      aar_pkg::S_F_CHK: begin
        if (adj_a) state_next = aar_pkg::S_D_RD;
        else state_next = f_last ? aar_pkg::S_SEL : aar_pkg::S_F_RD;
      end
      aar_pkg::S_D_RD:  state_next = aar_pkg::S_D_ACC;
      aar_pkg::S_D_ACC: state_next = j_last ? aar_pkg::S_W_CHK : aar_pkg::S_D_RD;
      aar_pkg::S_W_CHK: begin
        if (wtab[cnt] != '0) state_next = aar_pkg::S_C_RD;
        else state_next = f_last ? aar_pkg::S_SEL : aar_pkg::S_F_RD;
      end
      aar_pkg::S_C_RD:  state_next = aar_pkg::S_C_UPD;
      aar_pkg::S_C_UPD: begin
        if (!c_last) state_next = aar_pkg::S_C_RD;
        else state_next = f_last ? aar_pkg::S_SEL : aar_pkg::S_F_RD;
      end
      aar_pkg::S_SEL: begin
        if (cfg.limit == '0 || mark_cnt == '0) state_next = aar_pkg::S_EMPTY;
        else state_next = aar_pkg::S_S_RD;
      end
      aar_pkg::S_S_RD:  state_next = aar_pkg::S_S_CMP;
      aar_pkg::S_S_CMP: state_next = c_last ? aar_pkg::S_EMIT : aar_pkg::S_S_RD;
      aar_pkg::S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = emit_last ? aar_pkg::S_IDLE : aar_pkg::S_S_RD;
        end
      end
      aar_pkg::S_EMPTY: begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = aar_pkg::S_IDLE;
        end
      end
      default: state_next = aar_pkg::S_IDLE;
    endcase
  end

  // control: candidate flags, their count, output valid, clear address
  always_ff @(posedge clk) begin
    if (rst) begin
      marks <= '0;
      mark_cnt <= '0;
      out_valid <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (state == aar_pkg::S_CLR) clr_addr <= clr_addr + AAW'(1);
      if (state == aar_pkg::S_IDLE && in_acc && cmd_ch.cmd == aar_pkg::CMD_QUERY) begin
        marks <= '0;
        mark_cnt <= '0;
      end else if (sc_we) begin
        marks[c] <= 1'b1;
        if (!marks[c]) mark_cnt <= mark_cnt + MCW'(1);
      end else if (state == aar_pkg::S_EMIT && out_free) begin
        marks[best] <= 1'b0;
        mark_cnt <= mark_cnt - MCW'(1);
      end
      if (out_load) out_valid <= 1'b1;
      else if (rec_ch.ready) out_valid <= 1'b0;
    end
  end

  assign bs_x = SW'(bs);
  assign best_x = XW'(best);

  always_ff @(posedge clk) begin
    case (state)
      aar_pkg::S_IDLE: begin
        ea <= ax[NW-1:0];
        eb <= bx[NW-1:0];
        u  <= ax[NW-1:0];
        f  <= '0;
      end
      aar_pkg::S_F_CHK: begin
        j <= '0;
        cnt <= '0;
        if (!adj_a) f <= f + NW'(1);
      end
      aar_pkg::S_D_ACC: begin
        cnt <= cnt + DGW'(adj_a);
        j <= j + NW'(1);
      end
      aar_pkg::S_W_CHK: begin
        w <= wtab[cnt];
        c <= '0;
        if (wtab[cnt] == '0) f <= f + NW'(1);
      end
      aar_pkg::S_C_UPD: begin
        c <= c + NW'(1);
        if (c_last) f <= f + NW'(1);
      end
      aar_pkg::S_SEL: begin
        k <= '0;
        c <= '0;
        found <= 1'b0;
      end
      aar_pkg::S_S_CMP: begin
        if (marks[c] && (!found || sc_q >= bs)) begin
          best <= c;
          bs <= sc_q;
          found <= 1'b1;
        end
        c <= c + NW'(1);
      end
      aar_pkg::S_EMIT: begin
        if (out_free) begin
          rec_node  <= best_x[5:0];
          rec_score <= bs_x[23:0];
          empty_res <= 1'b0;
          last      <= emit_last;
          k <= k + aar_pkg::LIM_W'(1);
          c <= '0;
          found <= 1'b0;
        end
      end
      aar_pkg::S_EMPTY: begin
        if (out_free) begin
          rec_node  <= '0;
          rec_score <= '0;
          empty_res <= 1'b1;
          last      <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_ch.ready     = (state == aar_pkg::S_IDLE);
  assign rec_ch.valid     = out_valid;
  assign rec_ch.rec_node  = rec_node;
  assign rec_ch.rec_score = rec_score;
  assign rec_ch.empty_res = empty_res;
  assign rec_ch.last      = last;

`ifndef SYNTHESIS
  a_mark_cnt: assert property (@(posedge clk) disable iff (rst)
    mark_cnt == MCW'($countones(marks)))
    else $error("candidate count out of step with flags");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_res |-> rec_node == '0 && rec_score == '0 && last)
    else $error("empty word carries data");

  a_k_limit: assert property (@(posedge clk) disable iff (rst)
    state == aar_pkg::S_S_RD |-> k < cfg.limit && mark_cnt != '0)
    else $error("selection scan past result limit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rec_ch.ready |=> $stable(rec_node) && $stable(last))
    else $error("output word overwritten while stalled");
`endif

endmodule

/* test/adamic_adar_top_k_recommender_core_tb.sv */
module adamic_adar_top_k_recommender_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES      = 64;
  localparam int RES_MAX    = 16;
  localparam int STALL_MAX  = 200000;
  localparam int EDGE_DRAIN = 8;
  localparam logic [2:0] ADDR_NODE_COUNT   = 3'(4 * aar_pkg::REG_NODE_COUNT);
  localparam logic [2:0] ADDR_RESULT_LIMIT = 3'(4 * aar_pkg::REG_RESULT_LIMIT);

  typedef struct {
    logic [5:0]  node;
    logic [23:0] score;
    logic        empty_res;
    logic        last;
  } rec_t;

  class rec_scoreboard;
    logic [63:0]  adj[NODES];
    logic [17:0]  inv_ln[NODES + 1];
    int unsigned  node_count;
    int unsigned  res_limit;
    rec_t         pending[$];
    int           errors;

    function new();
      for (int i = 0; i < NODES; i++) adj[i] = '0;
      for (int d = 0; d <= NODES; d++) inv_ln[d] = weight_of(d);
      node_count = NODES;
      res_limit  = 4;
      errors     = 0;
    endfunction

    // 1/ln(d) in UQ2.16: log2 by repeated squaring in Q28, times ln2
    function logic [17:0] weight_of(int unsigned d);
      longint unsigned mant, lg, ln;
      int unsigned ip;
      if (d < 2) return '0;
      ip = 0;
      while ((d >> (ip + 1)) != 0) ip++;
      mant = (longint'(d) << 28) >> ip;
      lg = longint'(ip) << 28;
      for (int b = 27; b >= 0; b--) begin
        mant = (mant * mant) >> 28;
        if (mant >= (64'd1 << 29)) begin
          mant = mant >> 1;
          lg = lg | (64'd1 << b);
        end
      end
      ln = (lg * longint'(aar_pkg::LN2_Q32)) >> 32;
      if (ln == 0) return '0;
      return 18'(((64'd1 << 44) + ln / 2) / ln);
    endfunction

    function void set_node_count(int unsigned v);
      v = v & 7'h7f;
      node_count = (v > NODES) ? NODES : v;
    endfunction

    function void set_limit(int unsigned v);
      v = v & 5'h1f;
      res_limit = (v > RES_MAX) ? RES_MAX : v;
    endfunction

    function void note_word(logic op, logic [5:0] a, logic [5:0] b);
      logic [23:0] score[NODES];
      logic [63:0] marks, in_use;
      logic [24:0] sum;
      logic [17:0] w;
      rec_t r;
      int nc, deg, best, emitted;
      bit found;
      nc = node_count;
      in_use = (nc >= 64) ? '1 : ((64'd1 << nc) - 1);
      if (op == aar_pkg::CMD_EDGE) begin
        if (a != b && a < nc && b < nc) begin
          adj[a][b] = 1'b1;
          adj[b][a] = 1'b1;
        end
        return;
      end
      marks = '0;
      emitted = 0;
      for (int i = 0; i < NODES; i++) score[i] = '0;
      if (a < nc) begin
        for (int f = 0; f < nc; f++) begin
          if (!adj[a][f]) continue;
          deg = $countones(adj[f] & in_use);
          w = inv_ln[deg];
          if (w == 0) continue;
          for (int c = 0; c < nc; c++) begin
            if (c == a || !adj[f][c] || adj[a][c]) continue;
            sum = score[c] + w;
            score[c] = sum[24] ? '1 : sum[23:0];
            marks[c] = 1'b1;
          end
        end
        for (int k = 0; k < res_limit; k++) begin
          found = 0;
          best = 0;
          // >= while scanning upward puts the higher id first on a tie
          for (int c = 0; c < nc; c++) begin
            if (marks[c] && (!found || score[c] >= score[best])) begin
              best = c;
              found = 1;
            end
          end
          if (!found) break;
          marks[best] = 1'b0;
          r.node = 6'(best);
          r.score = score[best];
          r.empty_res = 1'b0;
          r.last = 1'b0;
          pending = {pending, r};
          emitted++;
        end
      end
      if (emitted == 0) begin
        r.node = '0;
        r.score = '0;
        r.empty_res = 1'b1;
        r.last = 1'b1;
        pending = {pending, r};
      end else begin
        pending[pending.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_rec(rec_t got);
      rec_t want;
      if (pending.size() == 0) begin
        $error("unexpected result word: node %0d score %0h", got.node, got.score);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.node !== want.node) begin
        $error("rec_node: expected %0d, got %0d", want.node, got.node);
        errors++;
      end
      if (got.score !== want.score) begin
        $error("rec_score: expected %0h, got %0h", want.score, got.score);
        errors++;
      end
      if (got.empty_res !== want.empty_res) begin
        $error("empty_res: expected %0b, got %0b", want.empty_res, got.empty_res);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  aar_cmd_if cmd_bus();
  aar_rec_if rec_bus();

  rec_scoreboard sb;
  int send_idle_pct;
  int rec_idle_pct;
  int stall_cycles;

  adamic_adar_top_k_recommender_core i_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .cmd_ch(cmd_bus),
    .rec_ch(rec_bus)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rec_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      rec_bus.ready <= ($urandom_range(99) >= rec_idle_pct);
    end
  end

  always @(posedge clk) begin
    rec_t got;
    if (!rst && rec_bus.valid && rec_bus.ready) begin
      got.node = rec_bus.rec_node;
      got.score = rec_bus.rec_score;
      got.empty_res = rec_bus.empty_res;
      got.last = rec_bus.last;
      sb.check_rec(got);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stall_cycles <= 0;
    end else if ((cmd_bus.valid && cmd_bus.ready) || (rec_bus.valid && rec_bus.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("** adamic_adar_top_k_recommender_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_word(logic op, logic [5:0] a, logic [5:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      cmd_bus.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_bus.valid <= 1'b1;
    cmd_bus.cmd <= op;
    cmd_bus.first_node <= a;
    cmd_bus.second_node <= b;
    do @(posedge clk); while (!cmd_bus.ready);
    sb.note_word(op, a, b);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    // an edge word may still be in flight with nothing expected
    repeat (EDGE_DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    wait_drained();
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_NODE_COUNT) sb.set_node_count(data);
    else sb.set_limit(data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    int nc_vals[];
    int span;
    nc_vals = '{8, 12, 16, 5, 24, 10, 64, 1, 20, 127, 14, 32};
    sb = new();
    send_idle_pct = 0;
    rec_idle_pct = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_bus.valid = 1'b0;
    cmd_bus.cmd = aar_pkg::CMD_EDGE;
    cmd_bus.first_node = '0;
    cmd_bus.second_node = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: small graph, self edge, repeated edge, isolated and bad user
    send_word(aar_pkg::CMD_EDGE, 6'd0, 6'd1);
    send_word(aar_pkg::CMD_EDGE, 6'd1, 6'd2);
    send_word(aar_pkg::CMD_EDGE, 6'd2, 6'd3);
    send_word(aar_pkg::CMD_EDGE, 6'd1, 6'd3);
    send_word(aar_pkg::CMD_EDGE, 6'd1, 6'd0);
    send_word(aar_pkg::CMD_EDGE, 6'd5, 6'd5);
    send_word(aar_pkg::CMD_EDGE, 6'd3, 6'd4);
    send_word(aar_pkg::CMD_QUERY, 6'd0, 6'd63);
    send_word(aar_pkg::CMD_QUERY, 6'd63, 6'd0);
    send_word(aar_pkg::CMD_EDGE, 6'd63, 6'd62);
    send_word(aar_pkg::CMD_EDGE, 6'd62, 6'd4);
    send_word(aar_pkg::CMD_QUERY, 6'd63, 6'd21);
    send_word(aar_pkg::CMD_QUERY, 6'd4, 6'd42);
    write_reg(ADDR_RESULT_LIMIT, 32'd0);
    send_word(aar_pkg::CMD_QUERY, 6'd0, 6'd0);
    write_reg(ADDR_RESULT_LIMIT, 32'd31);
    write_reg(ADDR_NODE_COUNT, 32'd127);
    send_word(aar_pkg::CMD_QUERY, 6'd1, 6'd0);
    write_reg(ADDR_NODE_COUNT, 32'd60);
    send_word(aar_pkg::CMD_EDGE, 6'd61, 6'd0);
    send_word(aar_pkg::CMD_EDGE, 6'd2, 6'd60);
    send_word(aar_pkg::CMD_QUERY, 6'd62, 6'd0);
    send_word(aar_pkg::CMD_QUERY, 6'd63, 6'd0);
    send_word(aar_pkg::CMD_QUERY, 6'd2, 6'd0);
    write_reg(ADDR_NODE_COUNT, 32'd1);
    send_word(aar_pkg::CMD_QUERY, 6'd0, 6'd0);

    for (int g = 0; g < 26; g++) begin
      if (g < 9) begin
        send_idle_pct = 18;
        rec_idle_pct = 75;
      end else if (g < 18) begin
        send_idle_pct = 75;
        rec_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        rec_idle_pct = 0;
      end
      if (g % 3 == 0) write_reg(ADDR_RESULT_LIMIT, $urandom_range(31));
      write_reg(ADDR_NODE_COUNT, nc_vals[g % nc_vals.size()]);
      span = (sb.node_count > 1) ? sb.node_count : 2;
      for (int e = 0; e < 13; e++) begin
        if ($urandom_range(9) == 0)
          send_word(aar_pkg::CMD_EDGE, 6'($urandom), 6'($urandom));
        else
          send_word(aar_pkg::CMD_EDGE, 6'($urandom_range(span - 1)),
                    6'($urandom_range(span - 1)));
      end
      if (g == 13) wait_drained();
      for (int q = 0; q < 4; q++) begin
        if ($urandom_range(9) == 0)
          send_word(aar_pkg::CMD_QUERY, 6'($urandom), 6'($urandom));
        else
          send_word(aar_pkg::CMD_QUERY, 6'($urandom_range(span - 1)), 6'($urandom));
      end
    end

    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** adamic_adar_top_k_recommender_core: PASSED **");
    end else begin
      $display("** adamic_adar_top_k_recommender_core: FAILED **");
    end
    $finish;
  end

endmodule

/* adamic_adar_top_k_recommender_core.f */
hw/rtl/aar_pkg.sv
hw/rtl/aar_cmd_if.sv
hw/rtl/aar_rec_if.sv
hw/rtl/aar_cfg.sv
hw/rtl/aar_adj_ram.sv
hw/rtl/aar_score_ram.sv
hw/rtl/adamic_adar_top_k_recommender_core.sv
test/adamic_adar_top_k_recommender_core_tb.sv
